// ----- sv/rdff_pkg.sv -----
`default_nettype none

package rdff_pkg;

    // Cache geometry and node id width
    localparam int CACHE_ENTRIES = 16;
    localparam int NODE_ID_BITS  = 64;
    localparam int PTR_BITS      = $clog2(CACHE_ENTRIES);

    // Configuration port
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 64;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IS_RELAY    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OWN_NODE_ID = CFG_INDEX_BITS'(1);

    typedef logic [NODE_ID_BITS-1:0] node_t;
    typedef logic [PTR_BITS-1:0]     ptr_t;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_DUPLICATE = 2'd1,
        ACT_EXPIRED   = 2'd2,
        ACT_FORWARD   = 2'd3
    } action_t;

    // Input item, first field in the highest bits
    typedef struct packed {
        logic [63:0] dest_node;
        logic [63:0] next_hop_node;
        logic [63:0] source_node;
        logic [7:0]  hop_limit;
        logic [7:0]  attempt;
        logic [7:0]  msg_type;
        logic [31:0] corr_id;
        logic [31:0] msg_id;
    } header_t;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic [63:0] out_next_hop;
        logic [7:0]  out_hop_limit;
        action_t     action;
    } result_t;

    localparam int S_TDATA_BITS = (($bits(header_t) + 7) / 8) * 8;
    localparam int M_TDATA_BITS = (($bits(result_t) + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- sv/relay_duplicate_filter_forward.sv -----
// Relay duplicate filter and forwarder.
//
// s_ channel: one routed message header per item. m_ channel: exactly one
// result item per header (action, decremented hop limit, new next hop).
// cfg channel: register writes (index 0 is_relay, index 1 own_node_id);
// cfg_ready is always high; write only while no item is in flight.
//
// A header is registered on acceptance, then compared against all cache
// entries in parallel; the cache update and the result register load happen
// together, when the output register can advance. m_tvalid rises when the
// result register loads, so each result passes the input register and then
// the result register. Throughput is one item per cycle while the receiver
// does not stall, set by the parallel key compare and round-robin cache write.
//
// Reset (aresetn low, synchronous) clears the config registers, all cache
// valid bits and the replace pointer, and empties both pipeline registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, then s_tready drops until m_tready returns.
`default_nettype none

module relay_duplicate_filter_forward (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [rdff_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [rdff_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // header input
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // msg_id, corr_id, msg_type, attempt, hop_limit,
    // source_node, next_hop_node, dest_node
    input  wire logic [rdff_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // result output
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // action, out_hop_limit, out_next_hop, zero pad
    output logic [rdff_pkg::M_TDATA_BITS-1:0]          m_tdata
);

    localparam int HDR_BITS = $bits(rdff_pkg::header_t);
    localparam int RES_BITS = $bits(rdff_pkg::result_t);
    localparam int NB       = rdff_pkg::NODE_ID_BITS;

    // Config registers
    logic            is_relay_reg;
    rdff_pkg::node_t own_node_id_reg;

    // Pipeline registers
    logic                in_valid_reg;
    rdff_pkg::header_t   in_reg;
    logic                out_valid_reg;
    rdff_pkg::result_t   result_reg;
    rdff_pkg::result_t   result_next;

    // Key cache
    logic [rdff_pkg::CACHE_ENTRIES-1:0] entry_valid_reg;
    logic [31:0]     entry_message_id_reg  [rdff_pkg::CACHE_ENTRIES];
    logic [31:0]     entry_correlation_reg [rdff_pkg::CACHE_ENTRIES];
    logic [7:0]      entry_type_reg        [rdff_pkg::CACHE_ENTRIES];
    logic [7:0]      entry_attempt_reg     [rdff_pkg::CACHE_ENTRIES];
    rdff_pkg::node_t entry_source_reg      [rdff_pkg::CACHE_ENTRIES];
    rdff_pkg::ptr_t  replace_ptr_reg;
    rdff_pkg::ptr_t  replace_ptr_next;

    logic                               advance;
    logic                               handled;
    logic                               hit;
    logic                               store;
    logic [rdff_pkg::CACHE_ENTRIES-1:0] entry_match;
    rdff_pkg::node_t                    src_id;

    // Handshakes
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(rdff_pkg::M_TDATA_BITS - RES_BITS){1'b0}}, result_reg};

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_relay_reg    <= 1'b0;
            own_node_id_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rdff_pkg::CFG_IS_RELAY:    is_relay_reg    <= cfg_data[0];
                rdff_pkg::CFG_OWN_NODE_ID: own_node_id_reg <= cfg_data[NB-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= rdff_pkg::header_t'(s_tdata[HDR_BITS-1:0]);
        end
    end

    // Parallel key compare against every cache entry
    assign src_id  = in_reg.source_node[NB-1:0];
    assign handled = is_relay_reg && (in_reg.next_hop_node[NB-1:0] == own_node_id_reg);

    always_comb begin
        for (int i = 0; i < rdff_pkg::CACHE_ENTRIES; i++) begin
            entry_match[i] = entry_valid_reg[i]
                && (entry_message_id_reg[i]  == in_reg.msg_id)
                && (entry_correlation_reg[i] == in_reg.corr_id)
                && (entry_type_reg[i]        == in_reg.msg_type)
                && (entry_attempt_reg[i]     == in_reg.attempt)
                && (entry_source_reg[i]      == src_id);
        end
    end

    assign hit   = |entry_match;
    assign store = in_valid_reg && advance && handled && !hit;

    // Round-robin replace pointer
    always_comb begin
        if (replace_ptr_reg == rdff_pkg::PTR_BITS'(rdff_pkg::CACHE_ENTRIES - 1)) begin
            replace_ptr_next = '0;
        end else begin
            replace_ptr_next = replace_ptr_reg + rdff_pkg::PTR_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            replace_ptr_reg <= '0;
        end else if (store) begin
            entry_valid_reg[replace_ptr_reg] <= 1'b1;
            replace_ptr_reg                  <= replace_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store) begin
            entry_message_id_reg[replace_ptr_reg]  <= in_reg.msg_id;
            entry_correlation_reg[replace_ptr_reg] <= in_reg.corr_id;
            entry_type_reg[replace_ptr_reg]        <= in_reg.msg_type;
            entry_attempt_reg[replace_ptr_reg]     <= in_reg.attempt;
            entry_source_reg[replace_ptr_reg]      <= src_id;
        end
    end

    // Result decision
    always_comb begin
        result_next = '0;
        if (!handled) begin
            result_next.action = rdff_pkg::ACT_NONE;
        end else if (hit) begin
            result_next.action = rdff_pkg::ACT_DUPLICATE;
        end else if (in_reg.hop_limit <= 8'd1) begin
            result_next.action = rdff_pkg::ACT_EXPIRED;
        end else begin
            result_next.action        = rdff_pkg::ACT_FORWARD;
            result_next.out_hop_limit = in_reg.hop_limit - 8'd1;
            result_next.out_next_hop  = 64'(in_reg.dest_node[NB-1:0]);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rdff_checker.sv -----
`default_nettype none

module rdff_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [rdff_pkg::M_TDATA_BITS-1:0]   m_tdata
);

    rdff_pkg::result_t res;
    assign res = rdff_pkg::result_t'(m_tdata[$bits(rdff_pkg::result_t)-1:0]);

    // A stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // After an accepted header passes the input register, a result is pending
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("no result pending after an accepted header");

    // Only forwarded items carry a hop limit and next hop
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.action != rdff_pkg::ACT_FORWARD
            |-> res.out_hop_limit == 8'd0 && res.out_next_hop == 64'd0)
        else $error("dropped item carries forward fields");

    // A forwarded item had a hop limit of at least two
    a_fwd_hop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.action == rdff_pkg::ACT_FORWARD |-> res.out_hop_limit != 8'd0)
        else $error("forwarded item with expired hop limit");

endmodule

bind relay_duplicate_filter_forward rdff_checker u_rdff_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int IDX_BITS = rdff_pkg::CFG_INDEX_BITS;
    localparam logic [IDX_BITS-1:0] CFG_UNUSED = IDX_BITS'(2);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int HOLD_OFF_AT = 600;
    localparam int KEY_POOL_DEPTH = 32;

    // Duplicate-detection key of one message
    typedef struct packed {
        logic [31:0]     mid;
        logic [31:0]     cor;
        logic [7:0]      typ;
        logic [7:0]      att;
        rdff_pkg::node_t src;
    } msg_key_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rdff_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [rdff_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [rdff_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rdff_pkg::M_TDATA_BITS-1:0] m_tdata;

    relay_duplicate_filter_forward dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the relay state
    logic            relay_on = 1'b0;
    rdff_pkg::node_t my_node = '0;
    logic            seen_live [rdff_pkg::CACHE_ENTRIES];
    msg_key_t        seen_key [rdff_pkg::CACHE_ENTRIES];
    rdff_pkg::ptr_t  replace_at = '0;

    rdff_pkg::header_t headers_to_send [$];
    rdff_pkg::result_t verdicts_due [$];
    msg_key_t          key_pool [$];

    bit steady = 1'b0;
    bit s_taken = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int results_seen = 0;
    int fails = 0;
    int quiet_cycles = 0;
    rdff_pkg::result_t got, want;

    initial begin
        for (int i = 0; i < rdff_pkg::CACHE_ENTRIES; i++) seen_live[i] = 1'b0;
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic rdff_pkg::header_t build(msg_key_t k, logic [7:0] hop,
                                                rdff_pkg::node_t nxt,
                                                rdff_pkg::node_t tgt);
        rdff_pkg::header_t h;
        h.msg_id         = k.mid;
        h.corr_id        = k.cor;
        h.msg_type       = k.typ;
        h.attempt        = k.att;
        h.hop_limit      = hop;
        h.source_node    = k.src;
        h.next_hop_node  = nxt;
        h.dest_node      = tgt;
        return h;
    endfunction

    // Forwarding decision for one header; updates the seen-key cache
    function automatic rdff_pkg::result_t relay_decision(rdff_pkg::header_t h);
        rdff_pkg::result_t r;
        msg_key_t          k;
        logic              hit;
        r = '0;
        r.action = rdff_pkg::ACT_NONE;
        if (!relay_on || h.next_hop_node[rdff_pkg::NODE_ID_BITS-1:0] != my_node) return r;
        k = '{h.msg_id, h.corr_id, h.msg_type, h.attempt,
              h.source_node[rdff_pkg::NODE_ID_BITS-1:0]};
        hit = 1'b0;
        for (int i = 0; i < rdff_pkg::CACHE_ENTRIES; i++)
            if (seen_live[i] && seen_key[i] == k) hit = 1'b1;
        if (hit) begin
            r.action = rdff_pkg::ACT_DUPLICATE;
            return r;
        end
        seen_live[replace_at] = 1'b1;
        seen_key[replace_at] = k;
        replace_at = replace_at + 1'b1;
        if (h.hop_limit <= 8'd1) begin
            r.action = rdff_pkg::ACT_EXPIRED;
            return r;
        end
        r.action = rdff_pkg::ACT_FORWARD;
        r.out_hop_limit = h.hop_limit - 8'd1;
        r.out_next_hop = 64'(h.dest_node[rdff_pkg::NODE_ID_BITS-1:0]);
        return r;
    endfunction

    // Random header: recent keys are reused or nudged so the cache sees hits
    function automatic rdff_pkg::header_t random_header();
        msg_key_t        k;
        logic [7:0]      hop;
        rdff_pkg::node_t nxt, tgt;
        int              r;
        r = $urandom_range(0, 99);
        if (key_pool.size() > 0 && r < 50) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if (r >= 38) begin
                case ($urandom_range(0, 4))
                    0: k.mid ^= 32'h1 << $urandom_range(0, 31);
                    1: k.cor ^= 32'h1 << $urandom_range(0, 31);
                    2: k.typ ^= 8'h1 << $urandom_range(0, 7);
                    3: k.att ^= 8'h1 << $urandom_range(0, 7);
                    default: k.src ^= 64'h1 << $urandom_range(0, 63);
                endcase
            end
        end else begin
            k.mid = $urandom();
            k.cor = $urandom();
            k.typ = 8'($urandom_range(0, 255));
            k.att = 8'($urandom_range(0, 255));
            k.src = {$urandom(), $urandom()};
        end
        key_pool.push_back(k);
        if (key_pool.size() > KEY_POOL_DEPTH) void'(key_pool.pop_front());
        case ($urandom_range(0, 9))
            0: hop = 8'd0;
            1: hop = 8'd1;
            2: hop = 8'd2;
            3: hop = 8'd255;
            default: hop = 8'($urandom_range(0, 255));
        endcase
        r = $urandom_range(0, 99);
        if (r < 80) nxt = my_node;
        else if (r < 90) nxt = my_node ^ (64'h1 << $urandom_range(0, 63));
        else nxt = {$urandom(), $urandom()};
        r = $urandom_range(0, 99);
        if (r < 10) tgt = '0;
        else if (r < 20) tgt = '1;
        else tgt = {$urandom(), $urandom()};
        return build(k, hop, nxt, tgt);
    endfunction

    task automatic write_reg(input logic [rdff_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [rdff_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rdff_pkg::CFG_IS_RELAY:    relay_on = val[0];
            rdff_pkg::CFG_OWN_NODE_ID: my_node = val[rdff_pkg::NODE_ID_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Block is idle once every header is sent and every result has arrived
    task automatic wait_idle();
        do @(posedge aclk);
        while (headers_to_send.size() != 0 || s_tvalid || verdicts_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input logic relay, input rdff_pkg::node_t node,
                             input bit calm, input int count);
        write_reg(rdff_pkg::CFG_IS_RELAY, 64'(relay));
        write_reg(rdff_pkg::CFG_OWN_NODE_ID, 64'(node));
        steady = calm;
        repeat (count) headers_to_send.push_back(random_header());
        wait_idle();
    endtask

    // Stimulus sequence
    initial begin
        msg_key_t ka, kb, kc, kv;
        ka = '0;
        kb = '1;
        kc = '{32'h1234_5678, 32'h9abc_def0, 8'h5a, 8'ha5, 64'h0123_4567_89ab_cdef};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Not a relay after reset; unknown register index must not change that
        write_reg(CFG_UNUSED, '1);
        headers_to_send.push_back(build(ka, 8'd255, '0, '1));
        wait_idle();

        write_reg(rdff_pkg::CFG_IS_RELAY, '1);
        write_reg(rdff_pkg::CFG_OWN_NODE_ID, '1);
        headers_to_send.push_back(build(ka, 8'd255, '1, '1));   // forward
        headers_to_send.push_back(build(ka, 8'd255, '1, '1));   // duplicate
        headers_to_send.push_back(build(kb, 8'd0, '1, '1));     // expired, still stored
        headers_to_send.push_back(build(kb, 8'd5, '1, '0));     // duplicate
        headers_to_send.push_back(build(kc, 8'd1, '1, '1));     // expired
        kv = kc;
        kv.mid = ~kv.mid;
        headers_to_send.push_back(build(kv, 8'd2, '1, '1));     // forward, hop 1
        // each key field on its own makes a new key
        kv = ka; kv.mid[0] = 1'b1;
        headers_to_send.push_back(build(kv, 8'd3, '1, 64'h1));
        kv = ka; kv.cor[31] = 1'b1;
        headers_to_send.push_back(build(kv, 8'd3, '1, 64'h2));
        kv = ka; kv.typ[0] = 1'b1;
        headers_to_send.push_back(build(kv, 8'd3, '1, 64'h3));
        kv = ka; kv.att[7] = 1'b1;
        headers_to_send.push_back(build(kv, 8'd3, '1, 64'h4));
        kv = ka; kv.src[63] = 1'b1;
        headers_to_send.push_back(build(kv, 8'd3, '1, 64'h5));
        // next hop off by one bit at either end
        headers_to_send.push_back(build(kc, 8'd9, ~64'h1, '1));
        headers_to_send.push_back(build(kc, 8'd9, ~(64'h1 << 63), '1));
        headers_to_send.push_back(build(ka, 8'd7, '1, '0));     // duplicate
        wait_idle();

        write_reg(rdff_pkg::CFG_OWN_NODE_ID, '0);
        headers_to_send.push_back(build(kc, 8'd200, '0, '1));
        headers_to_send.push_back(build(kc, 8'd200, '1, '1));   // not addressed here
        wait_idle();

        write_reg(rdff_pkg::CFG_IS_RELAY, '0);
        headers_to_send.push_back(build(kb, 8'd100, '0, '1));
        wait_idle();

        // Random traffic under several settings
        run_phase(1'b1, {$urandom(), $urandom()}, 1'b0, 400);
        run_phase(1'b1, '0, 1'b0, 350);
        run_phase(1'b1, '1, 1'b1, 350);
        run_phase(1'b0, {$urandom(), $urandom()}, 1'b0, 110);
        run_phase(1'b1, {$urandom(), $urandom()}, 1'b0, 380);
        run_phase(1'b1, {$urandom(), $urandom()}, 1'b0, 340);

        repeat (10) @(posedge aclk);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Header driver
    always @(negedge aclk) begin
        if (aresetn && !(s_tvalid && !s_taken)) begin
            s_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (headers_to_send.size() > 0) begin
                s_tdata <= headers_to_send.pop_front();
                s_tvalid <= 1'b1;
                send_gap = idle_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off that backs up the input
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    // Monitor: check results, then predict for accepted headers
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got = rdff_pkg::result_t'(m_tdata[$bits(rdff_pkg::result_t)-1:0]);
                if (verdicts_due.size() == 0) begin
                    $error("result item with no header pending: %h", m_tdata);
                    fails++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, got.action);
                        fails++;
                    end
                    if (got.out_hop_limit !== want.out_hop_limit) begin
                        $error("out_hop_limit: expected %0d, got %0d",
                               want.out_hop_limit, got.out_hop_limit);
                        fails++;
                    end
                    if (got.out_next_hop !== want.out_next_hop) begin
                        $error("out_next_hop: expected %h, got %h",
                               want.out_next_hop, got.out_next_hop);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                verdicts_due.push_back(relay_decision(rdff_pkg::header_t'(s_tdata)));
                s_taken = 1'b1;
            end
        end
    end

    // Watchdog on cycles with no item moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
